// ===== hdl/ring_route_traffic_accumulate_macros.svh =====
// Assertion macros for the ring route traffic accumulator.
// Used by the top level; expects signals clk and rst in scope.
`ifndef RING_ROUTE_TRAFFIC_ACCUMULATE_MACROS_SVH
`define RING_ROUTE_TRAFFIC_ACCUMULATE_MACROS_SVH
`ifndef ASSERT_OFF
`define RRA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rra check failed");
`define RRA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rra check failed");
`else
`define RRA_ASSERT(label, prop)
`define RRA_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hdl/rra_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes of the ring route traffic accumulator.
// No dependencies; the queue, front, back and top level files use it.
package rra_pkg;

  // Field widths
  localparam int CFG_W      = 5;
  localparam int NODE_W     = 5;
  localparam int IN_NODE_W  = 4;
  localparam int RATE_W     = 16;
  localparam int SUB_W      = 2;
  localparam int PORT_W     = 3;
  localparam int DIR_W      = 2;
  localparam int HOP_W      = 4;
  localparam int OUT_ACC_W  = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Defaults of the top level parameters
  localparam int DEF_MAX_NODES   = 16;
  localparam int DEF_NUM_SUBNETS = 3;
  localparam int DEF_ACC_WIDTH   = 32;

  // Table geometry and ring size limits
  localparam int IN_PORTS      = 5;
  localparam int OUT_DIRS      = 3;
  localparam int MIN_NODES     = 2;
  localparam int RESET_NODES   = 16;
  localparam int QUEUE_DEPTH   = 2;

  // Operation codes
  localparam logic FUNC_MARK = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Input port codes
  localparam logic [PORT_W-1:0] PORT_INJ  = 3'd0;
  localparam logic [PORT_W-1:0] PORT_CW0  = 3'd1;
  localparam logic [PORT_W-1:0] PORT_CW1  = 3'd2;
  localparam logic [PORT_W-1:0] PORT_CCW0 = 3'd3;
  localparam logic [PORT_W-1:0] PORT_CCW1 = 3'd4;

  // Output direction codes
  localparam logic [DIR_W-1:0] DIR_EJECT = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CW    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CCW   = 2'd2;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_MARK,
    CMD_READ
  } cmd_kind_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_WALK,
    B_DRAIN
  } back_state_t;

  // One input word, unpacked
  typedef struct packed {
    logic                 func;
    logic [IN_NODE_W-1:0] src;
    logic [IN_NODE_W-1:0] dst;
    logic [RATE_W-1:0]    rate;
    logic [SUB_W-1:0]     subnet;
    logic [IN_NODE_W-1:0] rd_router;
    logic [PORT_W-1:0]    rd_port;
    logic [DIR_W-1:0]     rd_dir;
  } item_t;

  // Classified command; src carries the router for a read
  typedef struct packed {
    cmd_kind_t         kind;
    logic [SUB_W-1:0]  sub;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [RATE_W-1:0] rate;
    logic              cw;
    logic [PORT_W-1:0] rd_port;
    logic [DIR_W-1:0]  rd_dir;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic [OUT_ACC_W-1:0] acc;
    logic [HOP_W-1:0]     hops;
    logic                 sat;
  } res_t;

endpackage

// ===== hdl/rra_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back parts.
// Depends on rra_pkg for the command type and queue depth.
module rra_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  rra_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output rra_pkg::cmd_t rd_cmd
);

  localparam int PTR_W = (rra_pkg::QUEUE_DEPTH > 1) ? $clog2(rra_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rra_pkg::QUEUE_DEPTH + 1);

  rra_pkg::cmd_t    slots [rra_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(rra_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_cmd   = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(rra_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(rra_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/rra_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts input words, checks indexes and picks the ring direction.
// Depends on rra_pkg; feeds classified commands to the queue.
module rra_front #(
  parameter int NUM_SUBNETS = rra_pkg::DEF_NUM_SUBNETS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rra_pkg::item_t             in_item,
  input  logic                       accept_en,
  input  logic [rra_pkg::CFG_W-1:0]  ring_nodes,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output rra_pkg::cmd_t              cmd
);

  logic [rra_pkg::NODE_W-1:0] src_x;
  logic [rra_pkg::NODE_W-1:0] dst_x;
  logic [rra_pkg::NODE_W-1:0] rr_x;
  logic [rra_pkg::NODE_W:0]   fwd_wrap;
  logic [rra_pkg::NODE_W-1:0] fwd;
  logic                       cw;
  logic                       sub_ok;
  logic                       mark_ok;
  logic                       read_ok;
  rra_pkg::cmd_t              new_cmd;
  logic                       f_valid;
  rra_pkg::cmd_t              f_cmd;

  assign src_x = rra_pkg::NODE_W'(in_item.src);
  assign dst_x = rra_pkg::NODE_W'(in_item.dst);
  assign rr_x  = rra_pkg::NODE_W'(in_item.rd_router);

  // Forward distance modulo the ring size, one compare and add
  assign fwd_wrap = {1'b0, dst_x} + {1'b0, ring_nodes} - {1'b0, src_x};
  assign fwd      = (dst_x >= src_x) ? (dst_x - src_x) : fwd_wrap[rra_pkg::NODE_W-1:0];
  assign cw       = ({fwd, 1'b0} <= {1'b0, ring_nodes});

  // Index checks
  assign sub_ok  = (32'(in_item.subnet) < 32'(NUM_SUBNETS));
  assign mark_ok = sub_ok && (src_x < ring_nodes) && (dst_x < ring_nodes);
  assign read_ok = sub_ok && (rr_x < ring_nodes)
                   && (in_item.rd_port < rra_pkg::PORT_W'(rra_pkg::IN_PORTS))
                   && (in_item.rd_dir < rra_pkg::DIR_W'(rra_pkg::OUT_DIRS));

  // Build the command
  always_comb begin
    new_cmd         = '0;
    new_cmd.sub     = in_item.subnet;
    new_cmd.dst     = dst_x;
    new_cmd.rate    = in_item.rate;
    new_cmd.cw      = cw;
    new_cmd.rd_port = in_item.rd_port;
    new_cmd.rd_dir  = in_item.rd_dir;
    if (in_item.func == rra_pkg::FUNC_READ) begin
      new_cmd.kind = read_ok ? rra_pkg::CMD_READ : rra_pkg::CMD_NOP;
      new_cmd.src  = rr_x;
    end else begin
      new_cmd.kind = mark_ok ? rra_pkg::CMD_MARK : rra_pkg::CMD_NOP;
      new_cmd.src  = src_x;
    end
  end

  assign in_ready  = accept_en && (!f_valid || cmd_ready);
  assign cmd_valid = f_valid;
  assign cmd       = f_cmd;

  // Hold the classified word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (cmd_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_cmd <= new_cmd;
    end
  end

endmodule

// ===== hdl/rra_back.sv =====
`timescale 1ns / 1ps
// Back part: walks the ring one hop per cycle and updates the traffic table.
// Depends on rra_pkg; holds the table memory and the clearing pass.
module rra_back #(
  parameter int MAX_NODES   = rra_pkg::DEF_MAX_NODES,
  parameter int NUM_SUBNETS = rra_pkg::DEF_NUM_SUBNETS,
  parameter int ACC_WIDTH   = rra_pkg::DEF_ACC_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  rra_pkg::cmd_t             cmd,
  input  logic [rra_pkg::CFG_W-1:0] ring_nodes,
  output logic                      res_valid,
  input  logic                      res_ready,
  output rra_pkg::res_t             res,
  output logic                      clearing
);

  localparam int DEPTH  = NUM_SUBNETS * MAX_NODES * rra_pkg::IN_PORTS * rra_pkg::OUT_DIRS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Table address of one accumulator
  function automatic logic [ADDR_W-1:0] slot(
    input logic [rra_pkg::SUB_W-1:0]  sub,
    input logic [rra_pkg::NODE_W-1:0] router,
    input logic [rra_pkg::PORT_W-1:0] prt,
    input logic [rra_pkg::DIR_W-1:0]  dir
  );
    int unsigned idx;
    idx = ((int'(sub) * MAX_NODES + int'(router)) * rra_pkg::IN_PORTS + int'(prt))
          * rra_pkg::OUT_DIRS + int'(dir);
    return ADDR_W'(idx);
  endfunction

  logic [ACC_WIDTH-1:0] mem [DEPTH];
  logic [ACC_WIDTH-1:0] mem_q;

  rra_pkg::back_state_t       state;
  rra_pkg::back_state_t       state_next;
  rra_pkg::cmd_t              cur_cmd;
  logic [rra_pkg::NODE_W-1:0] cur;
  logic [rra_pkg::NODE_W-1:0] cur_next;
  logic [rra_pkg::PORT_W-1:0] port;
  logic [rra_pkg::PORT_W-1:0] port_next;
  logic [rra_pkg::HOP_W-1:0]  hops;
  logic                       sat_acc;
  logic [ADDR_W-1:0]          clr_addr;

  logic                       upd_valid;
  logic                       upd_final;
  logic                       upd_write;
  logic [ADDR_W-1:0]          upd_addr;

  logic                       pop;
  logic                       issue;
  logic                       at_dst;
  logic                       issue_final;
  logic [ADDR_W-1:0]          issue_addr;
  logic [rra_pkg::NODE_W-1:0] n_last;
  logic [rra_pkg::DIR_W-1:0]  hop_dir;
  logic [ACC_WIDTH:0]         sum;
  logic                       upd_sat;
  logic [ACC_WIDTH-1:0]       acc_new;
  logic [63:0]                acc_wide;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [ACC_WIDTH-1:0]       mem_wdata;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rra_pkg::B_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = rra_pkg::B_IDLE;
        end
      end
      rra_pkg::B_IDLE: begin
        if (pop && cmd.kind != rra_pkg::CMD_NOP) begin
          state_next = rra_pkg::B_WALK;
        end
      end
      rra_pkg::B_WALK: begin
        if (issue_final) begin
          state_next = rra_pkg::B_DRAIN;
        end
      end
      rra_pkg::B_DRAIN: begin
        state_next = rra_pkg::B_IDLE;
      end
      default: begin
        state_next = rra_pkg::B_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    cmd_ready = 1'b0;
    issue     = 1'b0;
    clearing  = 1'b0;
    unique case (state)
      rra_pkg::B_CLEAR: clearing  = 1'b1;
      rra_pkg::B_IDLE:  cmd_ready = !res_valid || res_ready;
      rra_pkg::B_WALK:  issue     = 1'b1;
      rra_pkg::B_DRAIN: cmd_ready = 1'b0;
      default:          cmd_ready = 1'b0;
    endcase
  end

  assign pop = cmd_valid && cmd_ready;

  // Current hop: address and step to the next router
  assign n_last      = ring_nodes - rra_pkg::NODE_W'(1);
  assign at_dst      = (cur == cur_cmd.dst);
  assign hop_dir     = cur_cmd.cw ? rra_pkg::DIR_CW : rra_pkg::DIR_CCW;
  assign issue_final = (cur_cmd.kind == rra_pkg::CMD_READ) || at_dst;

  always_comb begin
    if (cur_cmd.kind == rra_pkg::CMD_READ) begin
      issue_addr = slot(cur_cmd.sub, cur, cur_cmd.rd_port, cur_cmd.rd_dir);
    end else if (at_dst) begin
      issue_addr = slot(cur_cmd.sub, cur, port, rra_pkg::DIR_EJECT);
    end else begin
      issue_addr = slot(cur_cmd.sub, cur, port, hop_dir);
    end
  end

  always_comb begin
    if (cur < n_last) begin
      if (cur_cmd.cw) begin
        cur_next = cur + rra_pkg::NODE_W'(1);
      end else if (cur == '0) begin
        cur_next = n_last;
      end else begin
        cur_next = cur - rra_pkg::NODE_W'(1);
      end
      if (port == rra_pkg::PORT_INJ) begin
        port_next = cur_cmd.cw ? rra_pkg::PORT_CW0 : rra_pkg::PORT_CCW0;
      end else begin
        port_next = port;
      end
    end else begin
      // Crossing the dateline switches to the second virtual channel
      cur_next = cur_cmd.cw ? '0 : cur - rra_pkg::NODE_W'(1);
      if (cur_cmd.cw) begin
        port_next = (port != rra_pkg::PORT_INJ) ? rra_pkg::PORT_CW1 : rra_pkg::PORT_CW0;
      end else begin
        port_next = (port != rra_pkg::PORT_INJ) ? rra_pkg::PORT_CCW1 : rra_pkg::PORT_CCW0;
      end
    end
  end

  // Saturating add of the rate to the read accumulator
  assign sum      = {1'b0, mem_q} + (ACC_WIDTH + 1)'(cur_cmd.rate);
  assign upd_sat  = sum[ACC_WIDTH];
  assign acc_new  = upd_sat ? '1 : sum[ACC_WIDTH-1:0];
  assign acc_wide = 64'(mem_q);

  // Write port: clearing pass or accumulator update
  assign mem_we    = clearing || (upd_valid && upd_write);
  assign mem_waddr = clearing ? clr_addr : upd_addr;
  assign mem_wdata = clearing ? '0 : acc_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      mem_q <= mem[issue_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rra_pkg::B_CLEAR;
      clr_addr  <= '0;
      upd_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      upd_valid <= issue;
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if ((pop && cmd.kind == rra_pkg::CMD_NOP) || (upd_valid && upd_final)) begin
        res_valid <= 1'b1;
      end
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cmd <= cmd;
      cur     <= cmd.src;
      port    <= rra_pkg::PORT_INJ;
      hops    <= '0;
      sat_acc <= 1'b0;
    end
    if (issue) begin
      upd_addr  <= issue_addr;
      upd_final <= issue_final;
      upd_write <= (cur_cmd.kind == rra_pkg::CMD_MARK);
      if (!issue_final) begin
        cur  <= cur_next;
        port <= port_next;
        hops <= hops + rra_pkg::HOP_W'(1);
      end
    end
    if (upd_valid && upd_write && upd_sat) begin
      sat_acc <= 1'b1;
    end
    if (pop && cmd.kind == rra_pkg::CMD_NOP) begin
      res <= '0;
    end else if (upd_valid && upd_final) begin
      res.acc  <= upd_write ? '0 : acc_wide[rra_pkg::OUT_ACC_W-1:0];
      res.hops <= upd_write ? hops : '0;
      res.sat  <= upd_write && (sat_acc || upd_sat);
    end
  end

endmodule

// ===== hdl/ring_route_traffic_accumulate.sv =====
`timescale 1ns / 1ps
// Ring route traffic accumulator: top level with stream ports and the
// ring size register. Depends on rra_pkg, rra_front, rra_fifo, rra_back.
//
// Usage: each input word on the s_ side either marks a path from src_node
// to dst_node on the ring (tuser 0) or reads one accumulator (tuser 1).
// Every input word gives exactly one output word on the m_ side.
// The user must write the ring size register on cfg_* only while the block is
// idle; the block itself does not enforce it. Values are clamped to
// 2..MAX_NODES. A mark walks the ring in the back part with one table
// read-modify-write per cycle plus start and drain; a read does a single
// table read, and a word with a bad index gives a zero result without a walk.
// The front part and a two-entry queue keep taking words while the back part
// works or the output waits.
// Reset: the table of NUM_SUBNETS*MAX_NODES*15 entries (720 by default) is
// cleared by a pass over every entry, during which s_tready stays low; cfg
// writes are taken.
// A stalled receiver holds m_tdata; the back part then stops after the next
// result and the queue fills before s_tready drops.
`include "ring_route_traffic_accumulate_macros.svh"
module ring_route_traffic_accumulate #(
  parameter int MAX_NODES   = rra_pkg::DEF_MAX_NODES,
  parameter int NUM_SUBNETS = rra_pkg::DEF_NUM_SUBNETS,
  parameter int ACC_WIDTH   = rra_pkg::DEF_ACC_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // src_node[3:0], dst_node[7:4], traffic_rate[23:8], subnet[25:24],
  // read_router[29:26], read_in_port[32:30], read_out_dir[34:33], zero [39:35]
  input  logic [rra_pkg::IN_TDATA_W-1:0]   s_tdata,
  // func[0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // acc_value[31:0], hop_count[35:32], saturated[36], zero [39:37]
  output logic [rra_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rra_pkg::CFG_W-1:0]        cfg_data
);

  localparam int RESET_N = (rra_pkg::RESET_NODES < MAX_NODES) ? rra_pkg::RESET_NODES : MAX_NODES;

  logic [rra_pkg::CFG_W-1:0] ring_nodes;
  rra_pkg::item_t            in_item;
  logic                      clearing;
  logic                      f_valid;
  logic                      f_ready;
  rra_pkg::cmd_t             f_cmd;
  logic                      q_valid;
  logic                      q_ready;
  rra_pkg::cmd_t             q_cmd;
  logic                      res_valid;
  logic                      res_ready;
  rra_pkg::res_t             res;
  rra_pkg::res_t             out_r;
  logic                      out_valid;

  // Ring size register, clamped on write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_nodes <= rra_pkg::CFG_W'(RESET_N);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data < rra_pkg::CFG_W'(rra_pkg::MIN_NODES)) begin
        ring_nodes <= rra_pkg::CFG_W'(rra_pkg::MIN_NODES);
      end else if (32'(cfg_data) > 32'(MAX_NODES)) begin
        ring_nodes <= rra_pkg::CFG_W'(MAX_NODES);
      end else begin
        ring_nodes <= cfg_data;
      end
    end
  end

  // Unpack the input word
  assign in_item.func      = s_tuser;
  assign in_item.src       = s_tdata[3:0];
  assign in_item.dst       = s_tdata[7:4];
  assign in_item.rate      = s_tdata[23:8];
  assign in_item.subnet    = s_tdata[25:24];
  assign in_item.rd_router = s_tdata[29:26];
  assign in_item.rd_port   = s_tdata[32:30];
  assign in_item.rd_dir    = s_tdata[34:33];

  rra_front #(
    .NUM_SUBNETS (NUM_SUBNETS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .accept_en  (!clearing),
    .ring_nodes (ring_nodes),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  rra_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  rra_back #(
    .MAX_NODES   (MAX_NODES),
    .NUM_SUBNETS (NUM_SUBNETS),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .ring_nodes (ring_nodes),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .clearing   (clearing)
  );

  // Output register
  assign res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_r.sat, out_r.hops, out_r.acc};

  // Checks
  `RRA_ASSERT(a_read_or_mark, !out_valid || out_r.acc == '0 || (out_r.hops == '0 && !out_r.sat))
  `RRA_ASSERT(a_queue_empty_clearing, !clearing || (!q_valid && !f_valid))
  `RRA_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid)

endmodule
